// ----- rtl/ppd_pkg.sv -----
`default_nettype none

package ppd_pkg;

  localparam int ROW_COUNT     = 64;
  localparam int CHANNEL_SLOTS = 32;
  localparam int ROW_W         = $clog2(ROW_COUNT + 1);

  localparam logic [7:0] NOTE_EMPTY = 8'hFF;
  localparam logic [3:0] NIB_OFF    = 4'hF;
  localparam logic [7:0] LETTER_S   = 8'd19;

  typedef enum logic [4:0] {
    EFF_NONE, EFF_A, EFF_B, EFF_C, EFF_D, EFF_E, EFF_F, EFF_G, EFF_H,
    EFF_I, EFF_J, EFF_K, EFF_L, EFF_O, EFF_P, EFF_Q, EFF_R,
    EFF_S3, EFF_S4, EFF_S8, EFF_SD, EFF_T, EFF_U, EFF_V, EFF_X
  } effect_code_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_start;
  } in_beat_t;

  typedef struct packed {
    logic [5:0] row_index;
    logic [4:0] channel_index;
    logic       has_note;
    logic [7:0] note_value;
    logic       note_release;
    logic [7:0] instrument_number;
    logic       has_volume;
    logic [7:0] volume_value;
    logic       has_effect;
    logic [4:0] effect_code;
    logic [7:0] effect_argument;
  } out_beat_t;

  // effect letter number (1 = A) to dense code; S is decoded apart
  function automatic effect_code_t letter_code(input logic [7:0] letter);
    effect_code_t c;
    c = EFF_NONE;
    case (letter)
      8'd1:    c = EFF_A;
      8'd2:    c = EFF_B;
      8'd3:    c = EFF_C;
      8'd4:    c = EFF_D;
      8'd5:    c = EFF_E;
      8'd6:    c = EFF_F;
      8'd7:    c = EFF_G;
      8'd8:    c = EFF_H;
      8'd9:    c = EFF_I;
      8'd10:   c = EFF_J;
      8'd11:   c = EFF_K;
      8'd12:   c = EFF_L;
      8'd15:   c = EFF_O;
      8'd16:   c = EFF_P;
      8'd17:   c = EFF_Q;
      8'd18:   c = EFF_R;
      8'd20:   c = EFF_T;
      8'd21:   c = EFF_U;
      8'd22:   c = EFF_V;
      8'd24:   c = EFF_X;
      default: c = EFF_NONE;
    endcase
    return c;
  endfunction

  function automatic effect_code_t s_code(input logic [3:0] hi);
    effect_code_t c;
    c = EFF_NONE;
    case (hi)
      4'h3:    c = EFF_S3;
      4'h4:    c = EFF_S4;
      4'h8:    c = EFF_S8;
      4'hD:    c = EFF_SD;
      default: c = EFF_NONE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/packed_pattern_decoder.sv -----
`default_nettype none
// Channel  Ports                                Beat
// in       in_valid / in_ready / in_data        one pattern byte, block start flag
// out      out_valid / out_ready / out_data     one decoded cell
// cfg      cfg_valid / cfg_ready / cfg_data     active channel count, always ready
//
// One input beat per clock while the skid register is empty; the parser state updates in the cycle the beat is taken.
// A cell is registered into the output register, or into the skid register while the output is stalled.
// Results sit in an output register backed by a one-entry skid register;
// in_ready drops only while the skid register is full.
// rst_n is synchronous: parser waits for a block start, channel count is zero.

module packed_pattern_decoder (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire ppd_pkg::in_beat_t in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output ppd_pkg::out_beat_t   out_data,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [5:0]            cfg_data
);
  import ppd_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT, PH_LENHI, PH_LEAD, PH_NOTE, PH_INST, PH_VOL, PH_EFF, PH_ARG
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [15:0]      left_r, left_nxt;
  logic [7:0]       lead_r, lead_nxt;
  logic [7:0]       note_r, note_nxt;
  logic [7:0]       inst_r, inst_nxt;
  logic [7:0]       vol_r, vol_nxt;
  logic [7:0]       eff_r, eff_nxt;
  logic [5:0]       active_r;

  out_beat_t        out_r, skid_r, res_beat;
  logic             out_valid_r, skid_valid_r;

  logic             in_fire, emit, produce;
  logic [7:0]       b, arg;
  logic [15:0]      len_full;
  logic [3:0]       note_hi;
  logic [7:0]       note_val;
  effect_code_t     code;
  logic [7:0]       arg_out;

  assign in_ready  = !skid_valid_r;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign b         = in_data.data_byte;
  assign len_full  = {b, left_r[7:0]};

  function automatic phase_t after_inst(input logic [7:0] l);
    phase_t p;
    if (l[6]) p = PH_VOL;
    else if (l[7]) p = PH_EFF;
    else p = PH_LEAD;
    return p;
  endfunction

  always_comb begin
    phase_nxt = phase_r;
    row_nxt   = row_r;
    left_nxt  = left_r;
    lead_nxt  = lead_r;
    note_nxt  = note_r;
    inst_nxt  = inst_r;
    vol_nxt   = vol_r;
    eff_nxt   = eff_r;
    emit      = 1'b0;
    arg       = 8'h00;
    if (in_data.block_start) begin
      left_nxt  = {8'h00, b};
      row_nxt   = '0;
      lead_nxt  = 8'h00;
      phase_nxt = PH_LENHI;
    end else begin
      if (phase_r != PH_WAIT && phase_r != PH_LENHI && phase_r != PH_LEAD
          && left_r != 16'd0) begin
        left_nxt = left_r - 16'd1;
      end
      case (phase_r)
        PH_WAIT: begin
        end
        PH_LENHI: begin
          left_nxt  = (len_full > 16'd2) ? len_full - 16'd2 : 16'd0;
          phase_nxt = PH_LEAD;
        end
        PH_LEAD: begin
          if (row_r < ROW_W'(ROW_COUNT) && left_r != 16'd0) begin
            left_nxt = left_r - 16'd1;
            if (b == 8'h00) begin
              row_nxt = row_r + ROW_W'(1);
            end else begin
              lead_nxt = b;
              note_nxt = 8'h00;
              inst_nxt = 8'h00;
              vol_nxt  = 8'h00;
              eff_nxt  = 8'h00;
              if (b[5]) phase_nxt = PH_NOTE;
              else phase_nxt = after_inst(b);
              emit = (phase_nxt == PH_LEAD);
            end
          end
        end
        PH_NOTE: begin
          note_nxt  = b;
          phase_nxt = PH_INST;
        end
        PH_INST: begin
          inst_nxt  = b;
          phase_nxt = after_inst(lead_r);
          emit      = (phase_nxt == PH_LEAD);
        end
        PH_VOL: begin
          vol_nxt   = b;
          phase_nxt = lead_r[7] ? PH_EFF : PH_LEAD;
          emit      = !lead_r[7];
        end
        PH_EFF: begin
          eff_nxt   = b;
          phase_nxt = PH_ARG;
        end
        PH_ARG: begin
          arg       = b;
          phase_nxt = PH_LEAD;
          emit      = 1'b1;
        end
        default: phase_nxt = PH_WAIT;
      endcase
    end
  end

  // cell built from the values as they stand after this byte
  assign note_hi  = note_nxt[7:4];
  assign note_val = {1'b0, note_hi, 3'b000} + {2'b00, note_hi, 2'b00}
                  + {4'h0, note_nxt[3:0]} + 8'd12;

  always_comb begin
    code    = EFF_NONE;
    arg_out = 8'h00;
    if (lead_nxt[7]) begin
      if (eff_nxt == LETTER_S) begin
        code    = s_code(arg[7:4]);
        arg_out = {4'h0, arg[3:0]};
      end else begin
        code    = letter_code(eff_nxt);
        arg_out = arg;
      end
    end
    res_beat.row_index         = row_r[5:0];
    res_beat.channel_index     = lead_nxt[4:0];
    res_beat.has_note          = lead_nxt[5];
    res_beat.note_release      = lead_nxt[5] && note_nxt != NOTE_EMPTY && note_hi == NIB_OFF;
    res_beat.note_value        = (lead_nxt[5] && note_nxt != NOTE_EMPTY && note_hi != NIB_OFF)
                                 ? note_val : 8'h00;
    res_beat.instrument_number = lead_nxt[5] ? inst_nxt : 8'h00;
    res_beat.has_volume        = lead_nxt[6];
    res_beat.volume_value      = lead_nxt[6] ? vol_nxt : 8'h00;
    res_beat.has_effect        = (code != EFF_NONE);
    res_beat.effect_code       = code;
    res_beat.effect_argument   = arg_out;
  end

  assign produce = in_fire && emit && ({1'b0, lead_nxt[4:0]} < active_r)
                   && ({1'b0, lead_nxt[4:0]} < 6'(CHANNEL_SLOTS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_WAIT;
      row_r        <= '0;
      left_r       <= 16'd0;
      lead_r       <= 8'h00;
      note_r       <= 8'h00;
      inst_r       <= 8'h00;
      vol_r        <= 8'h00;
      eff_r        <= 8'h00;
      active_r     <= 6'd0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) active_r <= cfg_data;
      if (in_fire) begin
        phase_r <= phase_nxt;
        row_r   <= row_nxt;
        left_r  <= left_nxt;
        lead_r  <= lead_nxt;
        note_r  <= note_nxt;
        inst_r  <= inst_nxt;
        vol_r   <= vol_nxt;
        eff_r   <= eff_nxt;
      end
      if (!out_valid_r || out_ready) begin
        if (skid_valid_r) begin
          out_r        <= skid_r;
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= produce;
          if (produce) out_r <= res_beat;
        end
      end else if (produce) begin
        skid_r       <= res_beat;
        skid_valid_r <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid beat held with empty output register");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_ready))
    else $error("skid filled while output could drain");

  a_effect_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data.has_effect == (out_data.effect_code != 5'd0)))
    else $error("effect flag disagrees with code");

  a_release_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data.note_release)
      |-> (out_data.note_value == 8'h00 && out_data.has_note))
    else $error("note-off carries a note value");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= ROW_W'(ROW_COUNT))
    else $error("row counter past end of pattern");

endmodule

`default_nettype wire

// ----- dv/packed_pattern_decoder_tb.sv -----
module packed_pattern_decoder_tb;
  import ppd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BEATS = 100;
  localparam logic [7:0] HAS_NOTE = 8'h20;
  localparam logic [7:0] HAS_VOL  = 8'h40;
  localparam logic [7:0] HAS_EFF  = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LEN_HI, ST_LEAD, ST_NOTE, ST_INST, ST_VOL, ST_EFF, ST_ARG
  } parse_st_t;

  typedef struct {
    in_beat_t  beat;
    bit        fixed;
    out_beat_t want;
  } probe_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [5:0] cfg_data;

  // tag travelling with the beat on the input channel
  bit        in_tagged;
  out_beat_t in_typed;

  probe_t    byte_queue[$];
  out_beat_t pending_cells[$];
  int        errors;
  int        cycle_count;
  bit        long_hold;

  // decoder copy
  parse_st_t  dec_phase;
  int         dec_row;
  int         dec_left;
  logic [7:0] dec_lead;
  logic [7:0] dec_note;
  logic [7:0] dec_inst;
  logic [7:0] dec_vol;
  logic [7:0] dec_eff;
  int         enabled_channels;

  effect_code_t letter_map [0:26] = '{
    EFF_NONE, EFF_A, EFF_B, EFF_C, EFF_D, EFF_E, EFF_F, EFF_G, EFF_H, EFF_I,
    EFF_J, EFF_K, EFF_L, EFF_NONE, EFF_NONE, EFF_O, EFF_P, EFF_Q, EFF_R, EFF_NONE,
    EFF_T, EFF_U, EFF_V, EFF_NONE, EFF_X, EFF_NONE, EFF_NONE
  };
  effect_code_t sub_map [0:15] = '{
    EFF_NONE, EFF_NONE, EFF_NONE, EFF_S3, EFF_S4, EFF_NONE, EFF_NONE, EFF_NONE,
    EFF_S8, EFF_NONE, EFF_NONE, EFF_NONE, EFF_NONE, EFF_SD, EFF_NONE, EFF_NONE
  };

  probe_t probes [28] = '{
    '{'{8'h81, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b1}, 1'b0, '0},
    '{'{8'h01, 1'b0}, 1'b0, '0},
    '{'{8'hE0, 1'b0}, 1'b0, '0},
    '{'{8'hFF, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b0, '0},
    '{'{8'hFF, 1'b0}, 1'b0, '0},
    '{'{8'h13, 1'b0}, 1'b0, '0},
    '{'{8'hDF, 1'b0}, 1'b1,
      '{6'd0, 5'd0, 1'b1, 8'd0, 1'b0, 8'h00, 1'b1, 8'hFF, 1'b1, EFF_SD, 8'h0F}},
    '{'{8'hA1, 1'b0}, 1'b0, '0},
    '{'{8'hF3, 1'b0}, 1'b0, '0},
    '{'{8'h01, 1'b0}, 1'b0, '0},
    '{'{8'h18, 1'b0}, 1'b0, '0},
    '{'{8'h80, 1'b0}, 1'b1,
      '{6'd0, 5'd1, 1'b1, 8'd0, 1'b1, 8'h01, 1'b0, 8'h00, 1'b1, EFF_X, 8'h80}},
    '{'{8'h82, 1'b0}, 1'b0, '0},
    '{'{8'h13, 1'b0}, 1'b0, '0},
    '{'{8'h1F, 1'b0}, 1'b1,
      '{6'd0, 5'd2, 1'b0, 8'd0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, EFF_NONE, 8'h0F}},
    '{'{8'h83, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b0, '0},
    '{'{8'h55, 1'b0}, 1'b1,
      '{6'd0, 5'd3, 1'b0, 8'd0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, EFF_NONE, 8'h55}},
    '{'{8'h1F, 1'b0}, 1'b1,
      '{6'd0, 5'd31, 1'b0, 8'd0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, EFF_NONE, 8'h00}},
    '{'{8'h44, 1'b0}, 1'b0, '0},
    '{'{8'h03, 1'b1}, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b0, '0},
    '{'{8'h45, 1'b0}, 1'b0, '0},
    '{'{8'h7F, 1'b0}, 1'b1,
      '{6'd0, 5'd5, 1'b0, 8'd0, 1'b0, 8'h00, 1'b1, 8'h7F, 1'b0, EFF_NONE, 8'h00}},
    '{'{8'h02, 1'b1}, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b0, '0}
  };

  packed_pattern_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  function automatic parse_st_t field_after(input parse_st_t from);
    if (from < ST_NOTE && (dec_lead & HAS_NOTE) != 0) return ST_NOTE;
    if (from < ST_VOL && (dec_lead & HAS_VOL) != 0) return ST_VOL;
    if (from < ST_EFF && (dec_lead & HAS_EFF) != 0) return ST_EFF;
    return ST_LEAD;
  endfunction

  function automatic bit finish_cell(input logic [7:0] arg_in, output out_beat_t c);
    logic [7:0]   arg;
    effect_code_t code;
    arg = arg_in;
    code = EFF_NONE;
    c = '0;
    if (int'(dec_lead[4:0]) >= enabled_channels) return 1'b0;
    c.row_index = dec_row[5:0];
    c.channel_index = dec_lead[4:0];
    if ((dec_lead & HAS_NOTE) != 0) begin
      c.has_note = 1'b1;
      c.instrument_number = dec_inst;
      if (dec_note == NOTE_EMPTY) begin
        c.note_value = 8'd0;
      end else if (dec_note[7:4] == NIB_OFF) begin
        c.note_release = 1'b1;
      end else begin
        c.note_value = 8'(int'(dec_note[7:4]) * 12 + int'(dec_note[3:0]) + 12);
      end
    end
    if ((dec_lead & HAS_VOL) != 0) begin
      c.has_volume = 1'b1;
      c.volume_value = dec_vol;
    end
    if ((dec_lead & HAS_EFF) != 0) begin
      if (dec_eff == LETTER_S) begin
        code = sub_map[arg[7:4]];
        arg = {4'h0, arg[3:0]};
      end else if (dec_eff < 8'd27) begin
        code = letter_map[dec_eff];
      end
      c.effect_code = code;
      c.has_effect = (code != EFF_NONE);
      c.effect_argument = arg;
    end
    return 1'b1;
  endfunction

  function automatic bit decode_byte(input in_beat_t b, output out_beat_t c);
    parse_st_t nxt;
    c = '0;
    nxt = ST_LEAD;
    if (b.block_start) begin
      dec_left = int'(b.data_byte);
      dec_row = 0;
      dec_lead = 8'h00;
      dec_phase = ST_LEN_HI;
      return 1'b0;
    end
    case (dec_phase)
      ST_IDLE: return 1'b0;
      ST_LEN_HI: begin
        dec_left = dec_left | (int'(b.data_byte) << 8);
        dec_left = (dec_left > 2) ? dec_left - 2 : 0;
        dec_phase = ST_LEAD;
        return 1'b0;
      end
      ST_LEAD: begin
        if (dec_row >= ROW_COUNT || dec_left == 0) return 1'b0;
        dec_left--;
        if (b.data_byte == 8'h00) begin
          dec_row++;
          return 1'b0;
        end
        dec_lead = b.data_byte;
        dec_note = 8'h00;
        dec_inst = 8'h00;
        dec_vol = 8'h00;
        dec_eff = 8'h00;
        dec_phase = field_after(ST_LEAD);
        if (dec_phase == ST_LEAD) return finish_cell(8'h00, c);
        return 1'b0;
      end
      default: ;
    endcase
    if (dec_left > 0) dec_left--;
    case (dec_phase)
      ST_NOTE: begin
        dec_note = b.data_byte;
        dec_phase = ST_INST;
        return 1'b0;
      end
      ST_INST: begin
        dec_inst = b.data_byte;
        nxt = field_after(ST_INST);
      end
      ST_VOL: begin
        dec_vol = b.data_byte;
        nxt = field_after(ST_VOL);
      end
      ST_EFF: begin
        dec_eff = b.data_byte;
        dec_phase = ST_ARG;
        return 1'b0;
      end
      ST_ARG: begin
        dec_phase = ST_LEAD;
        return finish_cell(b.data_byte, c);
      end
      default: begin
        dec_phase = ST_IDLE;
        return 1'b0;
      end
    endcase
    dec_phase = nxt;
    if (nxt == ST_LEAD) return finish_cell(8'h00, c);
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    out_beat_t c;
    bit        got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) enabled_channels = int'(cfg_data);
      if (in_valid && in_ready) begin
        got = decode_byte(in_data, c);
        if (in_tagged) begin
          pending_cells.push_back(in_typed);
        end else if (got) begin
          pending_cells.push_back(c);
        end
      end
    end
  end

  task automatic compare_cell(input out_beat_t want, input out_beat_t seen);
    if (seen.row_index !== want.row_index) begin
      $error("row_index: expected %0d, got %0d", want.row_index, seen.row_index);
      errors++;
    end
    if (seen.channel_index !== want.channel_index) begin
      $error("channel_index: expected %0d, got %0d", want.channel_index, seen.channel_index);
      errors++;
    end
    if (seen.has_note !== want.has_note) begin
      $error("has_note: expected %0d, got %0d", want.has_note, seen.has_note);
      errors++;
    end
    if (seen.note_value !== want.note_value) begin
      $error("note_value: expected %0d, got %0d", want.note_value, seen.note_value);
      errors++;
    end
    if (seen.note_release !== want.note_release) begin
      $error("note_release: expected %0d, got %0d", want.note_release, seen.note_release);
      errors++;
    end
    if (seen.instrument_number !== want.instrument_number) begin
      $error("instrument_number: expected %0d, got %0d",
             want.instrument_number, seen.instrument_number);
      errors++;
    end
    if (seen.has_volume !== want.has_volume) begin
      $error("has_volume: expected %0d, got %0d", want.has_volume, seen.has_volume);
      errors++;
    end
    if (seen.volume_value !== want.volume_value) begin
      $error("volume_value: expected %0d, got %0d", want.volume_value, seen.volume_value);
      errors++;
    end
    if (seen.has_effect !== want.has_effect) begin
      $error("has_effect: expected %0d, got %0d", want.has_effect, seen.has_effect);
      errors++;
    end
    if (seen.effect_code !== want.effect_code) begin
      $error("effect_code: expected %0d, got %0d", want.effect_code, seen.effect_code);
      errors++;
    end
    if (seen.effect_argument !== want.effect_argument) begin
      $error("effect_argument: expected %0d, got %0d",
             want.effect_argument, seen.effect_argument);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_cells.size() == 0) begin
        $error("cell beat with none pending: row %0d channel %0d",
               out_data.row_index, out_data.channel_index);
        errors++;
      end else begin
        compare_cell(pending_cells.pop_front(), out_data);
      end
    end
  end

  // receiver back-pressure
  initial begin
    int mode;
    int rx_cycle;
    mode = 0;
    rx_cycle = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        if (rx_cycle % 50 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= rx_cycle[2];
        endcase
        rx_cycle++;
      end
    end
  end

  function automatic void queue_byte(input logic [7:0] b, input logic s);
    probe_t p;
    p.beat.data_byte = b;
    p.beat.block_start = s;
    p.fixed = 1'b0;
    p.want = '0;
    byte_queue.push_back(p);
  endfunction

  task automatic feed_bytes();
    probe_t p;
    int     burst;
    int     gap;
    while (byte_queue.size() != 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && byte_queue.size() != 0) begin
        p = byte_queue.pop_front();
        in_valid <= 1'b1;
        in_data <= p.beat;
        in_tagged <= p.fixed;
        in_typed <= p.want;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic settle();
    repeat (2) @(posedge clk);
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_channels(input logic [5:0] n);
    cfg_valid <= 1'b1;
    cfg_data <= n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one pattern block, mostly well formed, with random contents
  task automatic make_block(input int chans);
    logic [7:0] body[$];
    logic [3:0] s_hi [4];
    int         rows;
    int         cells;
    int         len;
    int         cut;
    logic [7:0] lead;
    logic [7:0] tmp;
    s_hi = '{4'h3, 4'h4, 4'h8, 4'hD};
    rows = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
    for (int r = 0; r < rows; r++) begin
      // long blocks are mostly empty rows
      cells = (rows > 6 && $urandom_range(0, 7) != 0) ? 0 : $urandom_range(0, 3);
      for (int c = 0; c < cells; c++) begin
        lead[7:5] = 3'($urandom_range(0, 7));
        if (chans != 0 && $urandom_range(0, 1) == 1) begin
          lead[4:0] = 5'($urandom_range(0, chans - 1));
        end else begin
          lead[4:0] = 5'($urandom_range(0, 31));
        end
        body.push_back(lead);
        if ((lead & HAS_NOTE) != 0) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: tmp = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 11))};
            6: tmp = NOTE_EMPTY;
            7: tmp = 8'hF0 + 8'($urandom_range(0, 14));
            default: tmp = 8'($urandom_range(0, 255));
          endcase
          body.push_back(tmp);
          body.push_back(8'($urandom_range(0, 255)));
        end
        if ((lead & HAS_VOL) != 0) body.push_back(8'($urandom_range(0, 255)));
        if ((lead & HAS_EFF) != 0) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: begin
              body.push_back(8'($urandom_range(1, 26)));
              body.push_back(8'($urandom_range(0, 255)));
            end
            7, 8: begin
              body.push_back(LETTER_S);
              body.push_back({s_hi[$urandom_range(0, 3)], 4'($urandom_range(0, 15))});
            end
            default: begin
              body.push_back(8'($urandom_range(0, 255)));
              body.push_back(8'($urandom_range(0, 255)));
            end
          endcase
        end
      end
      body.push_back(8'h00);
    end
    len = body.size() + 2;
    case ($urandom_range(0, 9))
      8: len = (len > 6) ? len - $urandom_range(1, 6) : 0;
      9: len = $urandom_range(0, 65535);
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(0, body.size());
      while (body.size() > cut) void'(body.pop_back());
    end
    queue_byte(len[7:0], 1'b1);
    queue_byte(len[15:8], 1'b0);
    foreach (body[i]) queue_byte(body[i], 1'b0);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        queue_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
      end
    end
  endtask

  initial begin
    int phase_channels [8];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    in_tagged = 1'b0;
    in_typed = '0;
    cfg_valid = 1'b0;
    cfg_data = 6'd0;
    long_hold = 1'b0;
    errors = 0;
    dec_phase = ST_IDLE;
    dec_row = 0;
    dec_left = 0;
    dec_lead = 8'h00;
    dec_note = 8'h00;
    dec_inst = 8'h00;
    dec_vol = 8'h00;
    dec_eff = 8'h00;
    enabled_channels = 0;
    phase_channels = '{32, 0, 1, 31, 17, 32, 3, $urandom_range(0, 32)};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_channels(6'd32);
    foreach (probes[i]) byte_queue.push_back(probes[i]);
    feed_bytes();
    settle();

    foreach (phase_channels[p]) begin
      set_channels(6'(phase_channels[p]));
      // starve the output so the skid fills and the input stalls
      if (p == 5) long_hold = 1'b1;
      while (byte_queue.size() < PHASE_BEATS) make_block(phase_channels[p]);
      feed_bytes();
      settle();
    end

    repeat (8) @(posedge clk);
    if (errors == 0 && pending_cells.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
